// File: sv/sha_pkg.sv
package sha_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_COMP,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [5:0]  round;
	} rnd_ctl_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

// File: sv/sha256_hash_engine.sv
// channel | dir | tdata                                   | tuser
// s_axis  | in  | [31:0] msg_word, [34:32] word_bytes      | -  (tlast = last_word)
// m_axis  | out | [31:0] digest_word, [34:32] digest_index | -  (tlast = digest_last)
// A word's valid bytes (at most four) go into the block buffer one at a time; no new
// word is taken until they are in and any block they fill is compressed. A block runs
// its rounds, then a fold, on the shared round unit. The last word adds the padding
// bytes, one byte per cycle except while a full block is compressed, and one or two
// compressions, then 8 output transactions. Reset restores the initial hash and clears
// all buffers. Output stalls hold the digest word; no input is taken until the digest is out.
module sha256_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // msg_word[31:0], word_bytes[34:32], zero fill
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // digest_word[31:0], digest_index[34:32], zero fill
	output logic        m_axis_tlast
);
	sha_pkg::state_t st_q, st_d, st_nat, ret_q;
	logic [31:0] h_q [8];
	logic [31:0] blk_q [16];
	logic [5:0]  fill_q;
	logic [63:0] bits_q, len_q;
	logic [5:0]  rnd_q;
	logic [2:0]  cnt_q;
	logic [31:0] word_q;
	logic [2:0]  nb_q;
	logic        last_q, busy_q;
	logic [31:0] vout [8];
	sha_pkg::rnd_ctl_t ctl;
	logic [7:0]  byte_d;
	logic        put;
	logic [2:0]  nb_in;
	logic [31:0] mask;

	assign ctl.start = (st_q == sha_pkg::ST_COMP) && (rnd_q == 6'd0);
	assign ctl.round = rnd_q;

	sha_round u_rnd (.clk(clk), .ctl(ctl), .blk(blk_q), .hin(h_q), .vout(vout));

	assign nb_in = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
	assign s_axis_tready = (st_q == sha_pkg::ST_IDLE) && !busy_q;

	always_comb begin
		st_nat = st_q;
		case (st_q)
			sha_pkg::ST_IDLE: if (busy_q && nb_q == 3'd0)
				st_nat = last_q ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
			sha_pkg::ST_PAD: if (fill_q == 6'd55) st_nat = sha_pkg::ST_LEN;
			sha_pkg::ST_LEN: if (cnt_q == 3'd7) st_nat = sha_pkg::ST_COMP;
			sha_pkg::ST_COMP: if (rnd_q == 6'd63) st_nat = sha_pkg::ST_FOLD;
			sha_pkg::ST_FOLD: st_nat = (ret_q == sha_pkg::ST_COMP) ? sha_pkg::ST_OUT : ret_q;
			sha_pkg::ST_OUT: if (m_axis_tready && cnt_q == 3'd7) st_nat = sha_pkg::ST_IDLE;
			default: st_nat = sha_pkg::ST_IDLE;
		endcase
		st_d = (put && fill_q == 6'd63) ? sha_pkg::ST_COMP : st_nat;
	end

	always_comb begin
		put = 1'b0;
		byte_d = 8'h00;
		case (st_q)
			sha_pkg::ST_IDLE: begin
				put = busy_q && nb_q != 3'd0;
				byte_d = word_q[31:24];
			end
			sha_pkg::ST_PAD: begin
				put = 1'b1;
				byte_d = (cnt_q == 3'd0) ? sha_pkg::PAD_BYTE : 8'h00;
			end
			sha_pkg::ST_LEN: begin
				put = 1'b1;
				byte_d = len_q[63:56];
			end
			default: ;
		endcase
	end

	assign mask = 32'hff000000 >> {fill_q[1:0], 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sha_pkg::ST_IDLE;
			ret_q <= sha_pkg::ST_IDLE;
			h_q <= sha_pkg::IV;
			for (int i = 0; i < 16; i++) blk_q[i] <= '0;
			fill_q <= '0;
			bits_q <= '0;
			len_q <= '0;
			word_q <= '0;
			rnd_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			last_q <= 1'b0;
			nb_q <= '0;
		end else begin
			st_q <= st_d;
			if (s_axis_tvalid && s_axis_tready) begin
				busy_q <= 1'b1;
				word_q <= s_axis_tdata[31:0];
				nb_q <= nb_in;
				last_q <= s_axis_tlast;
			end
			if (put) begin
				blk_q[fill_q[5:2]] <= (blk_q[fill_q[5:2]] & ~mask)
					| ({24'd0, byte_d} << {~fill_q[1:0], 3'b000});
				fill_q <= fill_q + 6'd1;
				if (fill_q == 6'd63) ret_q <= st_nat;
			end
			if (st_q == sha_pkg::ST_IDLE && busy_q) begin
				if (nb_q != 3'd0) begin
					word_q <= {word_q[23:0], 8'h00};
					nb_q <= nb_q - 3'd1;
					bits_q <= bits_q + 64'd8;
				end else begin
					busy_q <= 1'b0;
					len_q <= bits_q;
					cnt_q <= '0;
				end
			end
			if (st_q == sha_pkg::ST_PAD) cnt_q <= 3'd1;
			if (st_q == sha_pkg::ST_PAD && fill_q == 6'd55) cnt_q <= '0;
			if (st_q == sha_pkg::ST_LEN) begin
				cnt_q <= cnt_q + 3'd1;
				len_q <= {len_q[55:0], 8'h00};
			end
			if (st_q == sha_pkg::ST_COMP) rnd_q <= rnd_q + 6'd1;
			if (st_q == sha_pkg::ST_FOLD) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + vout[i];
				if (ret_q == sha_pkg::ST_COMP) cnt_q <= '0;
			end
			if (st_q == sha_pkg::ST_OUT && m_axis_tready) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					h_q <= sha_pkg::IV;
					for (int i = 0; i < 16; i++) blk_q[i] <= '0;
					fill_q <= '0;
					bits_q <= '0;
				end
			end
		end
	end

	assign m_axis_tvalid = (st_q == sha_pkg::ST_OUT);
	assign m_axis_tdata = {5'd0, cnt_q, h_q[cnt_q]};
	assign m_axis_tlast = (cnt_q == 3'd7);

	a_rdy_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input ready during digest");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("digest changed under stall");
	a_comp_round: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == sha_pkg::ST_FOLD |-> $past(rnd_q) == 6'd63) else $error("fold early");
endmodule

// File: sv/sha_round.sv
// One compression round per cycle with a rolling 16-word message schedule.
module sha_round (
	input  logic                 clk,
	input  sha_pkg::rnd_ctl_t    ctl,
	input  logic [31:0]          blk [16],
	input  logic [31:0]          hin [8],
	output logic [31:0]          vout [8]
);
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] w_cur, w_new, s0, s1, e, a, ch, mj, t1, t2;
	logic [31:0] va [8];
	logic [31:0] wv [16];

	always_comb begin
		for (int i = 0; i < 16; i++) wv[i] = ctl.start ? blk[i] : w_q[i];
		for (int i = 0; i < 8; i++) va[i] = ctl.start ? hin[i] : v_q[i];
	end

	assign w_cur = wv[0];
	assign s0 = {wv[1][6:0], wv[1][31:7]} ^ {wv[1][17:0], wv[1][31:18]} ^ (wv[1] >> 3);
	assign s1 = {wv[14][16:0], wv[14][31:17]} ^ {wv[14][18:0], wv[14][31:19]}
		^ (wv[14] >> 10);
	assign w_new = s1 + wv[9] + s0 + wv[0];
	assign e = va[4];
	assign a = va[0];
	assign ch = (e & va[5]) ^ (~e & va[6]);
	assign mj = (a & va[1]) ^ (a & va[2]) ^ (va[1] & va[2]);
	assign t1 = va[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
		+ ch + sha_pkg::RK[ctl.round] + w_cur;
	assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]}) + mj;
	assign vout = v_q;

	always_ff @(posedge clk) begin
		v_q[7] <= va[6];
		v_q[6] <= va[5];
		v_q[5] <= va[4];
		v_q[4] <= va[3] + t1;
		v_q[3] <= va[2];
		v_q[2] <= va[1];
		v_q[1] <= va[0];
		v_q[0] <= t1 + t2;
		for (int i = 0; i < 15; i++) w_q[i] <= wv[i + 1];
		w_q[15] <= w_new;
	end
endmodule

// File: verif/sha256_hash_engine_tb.sv
`timescale 1ns / 1ps

module sha256_hash_engine_tb;

	localparam logic [31:0] HASH_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	logic [31:0] hash_state [8];
	logic [31:0] blk_buf [16];
	logic [5:0]  blk_fill;
	logic [63:0] msg_len_bits;

	logic [35:0] digest_queue [$];
	int          failures;
	bit          idle_en;
	int          stall_left;

	sha256_hash_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("sha256_hash_engine_tb failed");
		$finish;
	end

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress_buf();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) w[i] = blk_buf[i];
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endfunction

	function automatic void append_byte(logic [7:0] b);
		int sh;
		sh = (3 - blk_fill[1:0]) * 8;
		blk_buf[blk_fill[5:2]] = (blk_buf[blk_fill[5:2]] & ~(32'hff << sh)) | (32'(b) << sh);
		blk_fill = blk_fill + 6'd1;
		if (blk_fill == 6'd0) compress_buf();
	endfunction

	function automatic void reset_hash();
		for (int i = 0; i < 8; i++) hash_state[i] = HASH_INIT[i];
		for (int i = 0; i < 16; i++) blk_buf[i] = '0;
		blk_fill = '0;
		msg_len_bits = '0;
	endfunction

	function automatic void predict_word(logic [31:0] word, logic [2:0] nbytes, logic is_last);
		int          cnt;
		logic [63:0] len;
		cnt = (nbytes > 3'd4) ? 4 : int'(nbytes);
		for (int i = 0; i < cnt; i++) begin
			append_byte(word[31 - 8*i -: 8]);
			msg_len_bits += 64'd8;
		end
		if (!is_last) return;
		len = msg_len_bits;
		append_byte(8'h80);
		while (blk_fill != 6'd56) append_byte(8'h00);
		for (int i = 0; i < 8; i++) append_byte(len[63 - 8*i -: 8]);
		for (int i = 0; i < 8; i++)
			digest_queue.push_back({(i == 7), 3'(i), hash_state[i]});
		reset_hash();
	endfunction

	task automatic send_word(logic [31:0] word, logic [2:0] nbytes, logic is_last);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= {5'b0, nbytes, word};
		s_axis_tlast  <= is_last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_word(word, nbytes, is_last);
	endtask

	task automatic send_message(int nwords, bit noisy);
		logic [2:0] nb;
		for (int i = 0; i < nwords; i++) begin
			nb = noisy ? 3'($urandom_range(0, 7)) : 3'd4;
			if (noisy && $urandom_range(0, 1)) nb = 3'd4;
			send_word($urandom, nb, (i == nwords - 1));
		end
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 0;
		while (digest_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				m_axis_tready <= 0;
				stall_left <= stall_left - 1;
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 0;
				stall_left <= $urandom_range(0, 3);
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		logic [35:0] exp_d;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (digest_queue.size() == 0) begin
				$display("%0t: unexpected digest transaction %h", $time, m_axis_tdata);
				failures++;
			end else begin
				exp_d = digest_queue.pop_front();
				if (m_axis_tdata[31:0] !== exp_d[31:0] || m_axis_tdata[34:32] !== exp_d[34:32]
					|| m_axis_tdata[39:35] !== 5'b0 || m_axis_tlast !== exp_d[35]) begin
					$display("%0t: digest mismatch expected last=%b idx=%0d word=%h, actual last=%b tdata=%h",
						$time, exp_d[35], exp_d[34:32], exp_d[31:0], m_axis_tlast, m_axis_tdata);
					failures++;
				end
			end
		end
	end

	task automatic test_known_vectors();
		send_word(32'h0, 3'd0, 1);
		send_word(32'h616263ff, 3'd3, 1);
		send_word(32'hffffffff, 3'd4, 0);
		send_word(32'h12345678, 3'd0, 0);
		send_word(32'h00000000, 3'd4, 0);
		send_word(32'hdeadbeef, 3'd7, 0);
		send_word(32'ha5ffffff, 3'd1, 0);
		send_word(32'h5a3cffff, 3'd2, 0);
		send_word(32'h3c5aa5ff, 3'd5, 0);
		send_word(32'hffffffff, 3'd6, 1);
		wait_drain();
	endtask

	task automatic test_block_boundaries();
		send_message(14, 0);
		send_message(16, 0);
		wait_drain();
	endtask

	task automatic test_random_messages();
		for (int m = 0; m < 20; m++) send_message($urandom_range(1, 20), m % 3 == 0);
		wait_drain();
	endtask

	task automatic test_no_idling();
		idle_en = 0;
		for (int m = 0; m < 4; m++) send_message($urandom_range(1, 12), 1);
		wait_drain();
	endtask

	initial begin
		failures      = 0;
		idle_en       = 1;
		stall_left    = 0;
		arst_n        = 0;
		s_axis_tvalid = 0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 0;
		m_axis_tready = 0;
		reset_hash();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_known_vectors();
		test_block_boundaries();
		test_random_messages();
		test_no_idling();
		if (failures == 0)
			$display("sha256_hash_engine_tb passed");
		else
			$display("sha256_hash_engine_tb failed");
		$finish;
	end

endmodule

// File: sha256_hash_engine.f
sv/sha_pkg.sv
sv/sha_round.sv
sv/sha256_hash_engine.sv
verif/sha256_hash_engine_tb.sv
